// File: rtl/core/bmm_pkg.sv
// Shared types and constants for the bipartite matching engine.
package bmm_pkg;

    localparam int DEF_N_LEFT     = 256;
    localparam int DEF_N_RIGHT    = 256;
    localparam int DEF_MAX_DEGREE = 256;

    localparam int VERT_W  = 9;
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // register indexes on the configuration port
    localparam logic CFG_LEFT_COUNT  = 1'b0;
    localparam logic CFG_RIGHT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_RUN = 2'd1,
        OP_QRY = 2'd2,
        OP_CLR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_RANGE = 2'd1,
        RES_FULL  = 2'd2
    } t_res;

    typedef enum logic [4:0] {
        S_BOOT,
        S_IDLE,
        S_DECODE,
        S_ADD_RD,
        S_ADD_WR,
        S_QRY_RD,
        S_CLEAR,
        S_RUN_CLR,
        S_TRY,
        S_FETCH,
        S_EDGE,
        S_PART,
        S_MARK,
        S_POP,
        S_POP_LD,
        S_APPLY_TOP,
        S_APPLY_RD,
        S_APPLY_WR,
        S_NEXT_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic clr_deg;
        logic add_rd;
        logic add_wr;
        logic qry_rd;
        logic try_init;
        logic fetch;
        logic part_rd;
        logic mark_rd;
        logic advance;
        logic push;
        logic pop;
        logic pop_ld;
        logic apply_top;
        logic apply_rd;
        logic apply_wr;
        logic root_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic item_ok;
        logic clr_last;
        logic k_ge_deg;
        logic w_zero;
        logic blocked;
        logic sp_one;
        logic idx_zero;
        logic root_last;
        logic no_left;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/bipartite_max_matching.sv
// Top level of the bipartite matching engine: configuration port and core.
//
// Input channel (i_in_valid / o_in_stall) takes one item per beat: add edge,
// run matching, query a left vertex, or clear the graph. Output channel
// (o_out_valid / i_out_stall) gives exactly one result beat per item, in order.
// Items are handled one at a time; the result sits in an output register, so
// the next item is taken while that beat waits for the receiver.
// Add edge reads the degree store, then writes the edge and the new degree;
// query reads the left partner; an out-of-range add or query skips its store
// access. Clear sweeps the degree, partner and mark stores. Run sweeps the
// partner and mark stores, then per root does a depth-first search: each edge
// examined is fetched, its right partner read and its mark tested; a pop
// fetches, tests, pops and reloads; an augmenting path is written back one
// stack frame at a time. Steps wait on registered reads of the stores.
// The result beat appears on the cycle after it is loaded.
// After reset the block sweeps its degree, partner and mark stores with
// o_in_stall high; configuration writes are taken throughout.
// A stalled result beat holds; further results wait in the core until it
// drains. left_count and right_count reset to 256.
module bipartite_max_matching #(
    parameter int N_LEFT     = bmm_pkg::DEF_N_LEFT,
    parameter int N_RIGHT    = bmm_pkg::DEF_N_RIGHT,
    parameter int MAX_DEGREE = bmm_pkg::DEF_MAX_DEGREE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [bmm_pkg::VERT_W-1:0]  i_left_vertex,
    input  logic [bmm_pkg::VERT_W-1:0]  i_right_vertex,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic                        o_matched,
    output logic [bmm_pkg::VERT_W-1:0]  o_partner,
    output logic [bmm_pkg::COUNT_W-1:0] o_match_count
);
    import bmm_pkg::*;

    logic [COUNT_W-1:0] r_left_count;
    logic [COUNT_W-1:0] r_right_count;
    logic               cfg_wr;
    logic               cfg_idx;
    t_cmd               cmd;
    t_stat              stat;

    // register index is the word address; low byte bits are ignored
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // hold the counts; software must write them only while the core is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= COUNT_RESET;
            r_right_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == CFG_LEFT_COUNT)  r_left_count  <= pwdata[COUNT_W-1:0];
            if (cfg_idx == CFG_RIGHT_COUNT) r_right_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (cfg_idx == CFG_LEFT_COUNT) ? 32'(r_left_count)
                                                : 32'(r_right_count);

    // sequencer: one state per store access of the search
    bmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // stores, stack and result register
    bmm_dpath #(
        .N_LEFT     (N_LEFT),
        .N_RIGHT    (N_RIGHT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_left_count   (r_left_count),
        .i_right_count  (r_right_count),
        .i_operation    (i_operation),
        .i_left_vertex  (i_left_vertex),
        .i_right_vertex (i_right_vertex),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_matched      (o_matched),
        .o_partner      (o_partner),
        .o_match_count  (o_match_count)
    );

endmodule

// File: rtl/core/bmm_ctrl.sv
// Sequencer for the bipartite matching engine.
module bmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bmm_pkg::t_stat i_stat,
    output bmm_pkg::t_cmd  o_cmd
);
    import bmm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_BOOT: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_deg  = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_ADD:  n_state = i_stat.item_ok ? S_ADD_RD : S_DONE;
                    OP_RUN:  n_state = S_RUN_CLR;
                    OP_QRY:  n_state = i_stat.item_ok ? S_QRY_RD : S_DONE;
                    OP_CLR:  n_state = S_CLEAR;
                    default: n_state = S_DONE;
                endcase
            end
            S_ADD_RD: begin
                o_cmd.add_rd = 1'b1;
                n_state      = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_QRY_RD: begin
                o_cmd.qry_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_deg  = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_RUN_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = i_stat.no_left ? S_DONE : S_TRY;
            end
            S_TRY: begin
                o_cmd.try_init = 1'b1;
                n_state        = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EDGE;
            end
            S_EDGE: begin
                if (i_stat.k_ge_deg) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.part_rd = 1'b1;
                    n_state       = S_PART;
                end
            end
            S_PART: begin
                if (i_stat.w_zero) begin
                    n_state = S_APPLY_TOP;
                end else begin
                    o_cmd.mark_rd = 1'b1;
                    n_state       = S_MARK;
                end
            end
            S_MARK: begin
                if (i_stat.blocked) o_cmd.advance = 1'b1;
                else                o_cmd.push    = 1'b1;
                n_state = S_FETCH;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = i_stat.sp_one ? S_NEXT_ROOT : S_POP_LD;
            end
            S_POP_LD: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = S_FETCH;
            end
            S_APPLY_TOP: begin
                o_cmd.apply_top = 1'b1;
                n_state         = i_stat.sp_one ? S_NEXT_ROOT : S_APPLY_RD;
            end
            S_APPLY_RD: begin
                o_cmd.apply_rd = 1'b1;
                n_state        = S_APPLY_WR;
            end
            S_APPLY_WR: begin
                o_cmd.apply_wr = 1'b1;
                n_state        = i_stat.idx_zero ? S_NEXT_ROOT : S_APPLY_RD;
            end
            S_NEXT_ROOT: begin
                if (i_stat.root_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.root_next = 1'b1;
                    n_state         = S_TRY;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_BOOT;
        endcase
    end

endmodule

// File: rtl/core/bmm_dpath.sv
// Datapath of the matching engine: graph stores, search stack and result beat.
module bmm_dpath #(
    parameter int N_LEFT     = bmm_pkg::DEF_N_LEFT,
    parameter int N_RIGHT    = bmm_pkg::DEF_N_RIGHT,
    parameter int MAX_DEGREE = bmm_pkg::DEF_MAX_DEGREE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmm_pkg::t_cmd               i_cmd,
    output bmm_pkg::t_stat              o_stat,
    input  logic [bmm_pkg::COUNT_W-1:0] i_left_count,
    input  logic [bmm_pkg::COUNT_W-1:0] i_right_count,
    input  logic [1:0]                  i_operation,
    input  logic [bmm_pkg::VERT_W-1:0]  i_left_vertex,
    input  logic [bmm_pkg::VERT_W-1:0]  i_right_vertex,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic                        o_matched,
    output logic [bmm_pkg::VERT_W-1:0]  o_partner,
    output logic [bmm_pkg::COUNT_W-1:0] o_match_count
);
    import bmm_pkg::*;

    localparam int LVW   = $clog2(N_LEFT + 1);
    localparam int RVW   = $clog2(N_RIGHT + 1);
    localparam int LIW   = $clog2(N_LEFT);
    localparam int KW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int SPW   = $clog2(N_LEFT + 1);
    localparam int SIW   = $clog2(N_LEFT);
    localparam int EDEPTH = N_LEFT << KW;
    localparam int NCLR  = ((N_LEFT > N_RIGHT) ? N_LEFT : N_RIGHT) + 1;
    localparam int CW    = $clog2(NCLR);
    localparam int FW    = LVW + DW + RVW;

    typedef struct packed {
        logic [LVW-1:0] v;
        logic [DW-1:0]  k;
        logic [RVW-1:0] u;
    } t_frame;

    // stores
    logic [DW-1:0]  m_deg  [0:N_LEFT];
    logic [RVW-1:0] m_edge [0:EDEPTH-1];
    logic [RVW-1:0] m_lp   [0:N_LEFT];
    logic [LVW-1:0] m_rp   [0:N_RIGHT];
    logic [LVW-1:0] m_mark [0:N_LEFT];
    logic [FW-1:0]  m_stk  [0:N_LEFT-1];

    logic [DW-1:0]  r_deg_q;
    logic [RVW-1:0] r_edge_q;
    logic [RVW-1:0] r_lp_q;
    logic [LVW-1:0] r_rp_q;
    logic [LVW-1:0] r_mark_q;
    t_frame         r_stk_q;

    // item and search state
    t_op            r_op;
    logic [LVW-1:0] r_lv;
    logic [RVW-1:0] r_rv;
    logic           r_ok;
    logic           r_full;
    logic [CW-1:0]  r_clr;
    logic [LVW-1:0] r_root;
    logic [LVW-1:0] r_v;
    logic [DW-1:0]  r_k;
    logic [SPW-1:0] r_sp;
    logic [SIW-1:0] r_idx;
    logic [COUNT_W-1:0] r_pairs;

    logic           r_out_valid;
    logic [1:0]     r_status;
    logic           r_matched;
    logic [VERT_W-1:0] r_partner;
    logic [COUNT_W-1:0] r_match_count;

    logic           lv_ok, rv_ok, in_ok;
    logic [LVW-1:0] v_dec, lv_dec;
    logic [SPW-1:0] sp_dec1, sp_dec2;
    logic [SIW-1:0] stk_ra;
    logic           qry_hit;

    assign lv_ok = (i_left_vertex != '0) && (i_left_vertex <= i_left_count)
                   && (32'(i_left_vertex) <= N_LEFT);
    assign rv_ok = (i_right_vertex != '0) && (i_right_vertex <= i_right_count)
                   && (32'(i_right_vertex) <= N_RIGHT);

    always_comb begin
        case (t_op'(i_operation))
            OP_ADD:  in_ok = lv_ok && rv_ok;
            OP_QRY:  in_ok = lv_ok;
            default: in_ok = 1'b1;
        endcase
    end

    assign v_dec   = r_v - LVW'(1);
    assign lv_dec  = r_lv - LVW'(1);
    assign sp_dec1 = r_sp - SPW'(1);
    assign sp_dec2 = r_sp - SPW'(2);
    assign stk_ra  = i_cmd.apply_rd ? r_idx : sp_dec2[SIW-1:0];

    // degree store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && i_cmd.clr_deg) begin
            m_deg[r_clr[LVW-1:0]] <= '0;
        end else if (i_cmd.add_wr && !(32'(r_deg_q) >= MAX_DEGREE)) begin
            m_deg[r_lv] <= r_deg_q + DW'(1);
        end
        if (i_cmd.add_rd) begin
            r_deg_q <= m_deg[r_lv];
        end else if (i_cmd.fetch) begin
            r_deg_q <= m_deg[r_v];
        end
    end

    // adjacency rows, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr && !(32'(r_deg_q) >= MAX_DEGREE)) begin
            m_edge[{lv_dec[LIW-1:0], r_deg_q[KW-1:0]}] <= r_rv;
        end
        if (i_cmd.fetch) begin
            r_edge_q <= m_edge[{v_dec[LIW-1:0], r_k[KW-1:0]}];
        end
    end

    // left partners
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_lp[r_clr[LVW-1:0]] <= '0;
        end else if (i_cmd.apply_top) begin
            m_lp[r_v] <= r_edge_q;
        end else if (i_cmd.apply_wr) begin
            m_lp[r_stk_q.v] <= r_stk_q.u;
        end
        if (i_cmd.qry_rd) begin
            r_lp_q <= m_lp[r_lv];
        end
    end

    // right partners
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_rp[r_clr[RVW-1:0]] <= '0;
        end else if (i_cmd.apply_top) begin
            m_rp[r_edge_q] <= r_v;
        end else if (i_cmd.apply_wr) begin
            m_rp[r_stk_q.u] <= r_stk_q.v;
        end
        if (i_cmd.part_rd) begin
            r_rp_q <= m_rp[r_edge_q];
        end
    end

    // visited marks: an entry equal to the current root counts as visited
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_mark[r_clr[LVW-1:0]] <= '0;
        end else if (i_cmd.try_init) begin
            m_mark[r_root] <= r_root;
        end else if (i_cmd.push) begin
            m_mark[r_rp_q] <= r_root;
        end
        if (i_cmd.mark_rd) begin
            r_mark_q <= m_mark[r_rp_q];
        end
    end

    // search stack; the top frame lives in r_v / r_k / r_edge_q
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            m_stk[sp_dec1[SIW-1:0]] <= FW'({r_v, r_k, r_edge_q});
        end
        if (i_cmd.pop || i_cmd.apply_rd) begin
            r_stk_q <= t_frame'(m_stk[stk_ra]);
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_operation);
            r_lv   <= LVW'(i_left_vertex);
            r_rv   <= RVW'(i_right_vertex);
            r_ok   <= in_ok;
            r_full <= 1'b0;
        end else if (i_cmd.add_wr) begin
            r_full <= (32'(r_deg_q) >= MAX_DEGREE);
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pairs <= '0;
            r_root  <= LVW'(1);
            r_sp    <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr   <= (32'(r_clr) == NCLR - 1) ? '0 : r_clr + CW'(1);
                r_pairs <= '0;
                r_root  <= LVW'(1);
            end
            if (i_cmd.root_next) r_root <= r_root + LVW'(1);
            if (i_cmd.try_init) begin
                r_v  <= r_root;
                r_k  <= '0;
                r_sp <= SPW'(1);
            end else if (i_cmd.advance) begin
                r_k <= r_k + DW'(1);
            end else if (i_cmd.push) begin
                r_v  <= r_rp_q;
                r_k  <= '0;
                r_sp <= r_sp + SPW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= sp_dec1;
            end else if (i_cmd.pop_ld) begin
                r_v <= r_stk_q.v;
                r_k <= r_stk_q.k + DW'(1);
            end
            if (i_cmd.apply_top) begin
                r_pairs <= r_pairs + COUNT_W'(1);
                r_idx   <= sp_dec2[SIW-1:0];
            end else if (i_cmd.apply_wr) begin
                r_idx <= r_idx - SIW'(1);
            end
        end
    end

    // result beat
    assign qry_hit = (r_op == OP_QRY) && r_ok && (r_lp_q != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (!r_ok)                          r_status <= RES_RANGE;
            else if (r_op == OP_ADD && r_full)  r_status <= RES_FULL;
            else                                r_status <= RES_OK;
            r_matched     <= qry_hit;
            r_partner     <= qry_hit ? VERT_W'(r_lp_q) : '0;
            r_match_count <= r_pairs;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_matched     = r_matched;
    assign o_partner     = r_partner;
    assign o_match_count = r_match_count;

    // status towards the sequencer
    assign o_stat.op        = r_op;
    assign o_stat.item_ok   = r_ok;
    assign o_stat.clr_last  = (32'(r_clr) == NCLR - 1);
    assign o_stat.k_ge_deg  = (r_k >= r_deg_q);
    assign o_stat.w_zero    = (r_rp_q == '0);
    assign o_stat.blocked   = (r_mark_q == r_root) || (32'(r_sp) >= N_LEFT);
    assign o_stat.sp_one    = (r_sp == SPW'(1));
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.root_last = (32'(r_root) >= 32'(i_left_count))
                              || (32'(r_root) >= N_LEFT);
    assign o_stat.no_left   = (i_left_count == '0);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    a_push_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_mark_q != r_root))
        else $error("push of a vertex already visited in this try");

    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply_top |-> (r_rp_q == '0))
        else $error("augmenting path ends on a matched right vertex");

    a_add_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |-> r_ok)
        else $error("edge written for an out-of-range item");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result beat lost after load");

endmodule
